// ----- rtl/gthq_pkg.sv -----
// ----------------------------------------------------------------------------
// gthq_pkg
// Types, widths and tables shared by the grid terrain height query block.
// ----------------------------------------------------------------------------
package gthq_pkg;

    localparam int CFG_W            = 11;
    localparam int CFG_IDX_W        = 2;
    localparam int VIDX_W           = 10;
    localparam int COORD_W          = 32;
    localparam int DIFF_W           = 33;
    localparam int MUL_A_W          = 35;
    localparam int PROD_W           = 68;
    localparam int NORM_W           = 67;
    localparam int NUM_W            = 102;
    localparam int REM_W            = 68;
    localparam int ADDR_FULL_W      = 23;
    localparam int STEP_W           = 3;
    localparam int DIV_CNT_W        = 7;
    localparam int DEF_MAX_VERTICES = 1024;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    localparam logic [CFG_IDX_W-1:0] REG_GRID_COLUMNS  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GRID_ROWS     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_QUERY_ENABLED = 2'd2;

    localparam logic [1:0] CORNER_UL = 2'd0;
    localparam logic [1:0] CORNER_UR = 2'd1;
    localparam logic [1:0] CORNER_LL = 2'd2;
    localparam logic [1:0] CORNER_LR = 2'd3;

    // right triangle edges first, then left triangle edges
    localparam logic [1:0] EDGE_HEAD [6] = '{CORNER_LR, CORNER_UR, CORNER_UL,
                                             CORNER_LL, CORNER_UL, CORNER_LR};
    localparam logic [1:0] EDGE_TAIL [6] = '{CORNER_UL, CORNER_LR, CORNER_UR,
                                             CORNER_UL, CORNER_LR, CORNER_LL};

    localparam logic [62:0] QUOT_LIMIT = 63'h4000_0000_0000_0000;

    typedef struct packed {
        logic                      opcode;
        logic [VIDX_W-1:0]         vertex_index;
        logic signed [COORD_W-1:0] coord_x;
        logic signed [COORD_W-1:0] coord_y;
        logic signed [COORD_W-1:0] coord_z;
    } request_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] height;
        logic                      triangle_found;
        logic                      flat_normal_error;
    } response_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic signed [COORD_W-1:0] z;
    } vertex_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_EDGE,
        ST_DECIDE,
        ST_NORMAL,
        ST_NUMER,
        ST_DIVIDE,
        ST_FINISH
    } state_t;

    function automatic logic signed [DIFF_W-1:0] sub33(input logic signed [COORD_W-1:0] a,
                                                        input logic signed [COORD_W-1:0] b);
        sub33 = {a[COORD_W-1], a} - {b[COORD_W-1], b};
    endfunction

    function automatic logic signed [MUL_A_W-1:0] ext35(input logic signed [DIFF_W-1:0] d);
        ext35 = {{(MUL_A_W-DIFF_W){d[DIFF_W-1]}}, d};
    endfunction

endpackage

// ----- rtl/grid_terrain_height_query.sv -----
// ----------------------------------------------------------------------------
// grid_terrain_height_query
// Height of a position over a grid mesh held in an on-chip vertex memory.
// ----------------------------------------------------------------------------
// Channel   Signals                        Direction  Handshake
// config    cfg_we, cfg_idx, cfg_data      in         write when cfg_we high
// request   start, busy, request           in         item taken on start & !busy
// response  done, response                 out        one-cycle strobe on done
//
// A write item, a disabled query or a grid with no cells finishes in the
// accepting cycle; any result appears on the next cycle and busy stays low.
// A scanned query tests the cells in turn (memory reads of the cell's corners, edge
// cross products for both triangles on the shared multiplier pair); a hit goes on to the
// normal, the numerator and the 102-step restoring divider, which stops at
// once when the normal's y is zero; a full miss goes straight to the finish.
// Reset returns control and configuration to their defaults; the vertex memory is not cleared.
// The receiver cannot stall: done is high for exactly one cycle per query.
// ----------------------------------------------------------------------------
module grid_terrain_height_query #(
    parameter int MAX_VERTICES = gthq_pkg::DEF_MAX_VERTICES
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [gthq_pkg::CFG_IDX_W-1:0]   cfg_idx,
    input  logic [gthq_pkg::CFG_W-1:0]       cfg_data,
    input  logic                             start,
    output logic                             busy,
    input  gthq_pkg::request_t               request,
    output logic                             done,
    output gthq_pkg::response_t              response
);
    import gthq_pkg::*;

    localparam int ADDR_W = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;

    state_t                        state_reg, state_next;
    logic [STEP_W-1:0]             step_reg, step_next;
    logic [CFG_W-1:0]              cols_reg, rows_reg;
    logic                          enable_reg;
    logic [CFG_W-1:0]              x_reg, z_reg;
    logic [ADDR_FULL_W-1:0]        base_reg;
    logic signed [COORD_W-1:0]     px_reg, py_reg, pz_reg;
    vertex_t                       mem [MAX_VERTICES];
    vertex_t                       rd_q_reg;
    logic                          rd_zero_reg;
    vertex_t                       corner_reg [4];
    logic signed [PROD_W-1:0]      prod_a_reg, prod_b_reg;
    logic [5:0]                    edge_ok_reg;
    logic                          right_sel_reg, found_reg;
    logic signed [NORM_W-1:0]      nx_reg, ny_reg, nz_reg;
    logic signed [NUM_W-1:0]       num_reg;
    logic [NUM_W-1:0]              dvd_reg, quo_reg;
    logic [REM_W-1:0]              rem_reg;
    logic [DIV_CNT_W-1:0]          div_cnt_reg;
    response_t                     response_reg;
    logic                          done_reg;

    logic                          accept, is_query, small_grid;
    logic                          mem_we, rd_en;
    logic [ADDR_FULL_W-1:0]        wr_full, rd_addr;
    logic signed [MUL_A_W-1:0]     mul_a0, mul_a1;
    logic signed [DIFF_W-1:0]      mul_b0, mul_b1;
    logic [2:0]                    edge_sel;
    vertex_t                       head_v, tail_v, v0, v1, v2;
    logic signed [DIFF_W-1:0]      e0x, e0y, e0z, e1x, e1y, e1z, dx, dz;
    logic signed [PROD_W:0]        prod_diff;
    logic signed [NUM_W-1:0]       prod_sum, num_full;
    logic [NUM_W-1:0]              num_abs;
    logic [REM_W-1:0]              ny_abs, rem_shift;
    logic                          right_hit, left_hit, last_col, last_cell;
    logic                          ny_zero, num_zero, quo_over, quot_neg, div_last;
    logic [62:0]                   mag;
    logic signed [63:0]            quot_s, h64;
    logic signed [COORD_W-1:0]     h_sat;

    assign accept     = start && !busy;
    assign is_query   = request.opcode == OP_QUERY;
    assign small_grid = (cols_reg < CFG_W'(2)) || (rows_reg < CFG_W'(2));
    assign busy       = state_reg != ST_IDLE;
    assign done       = done_reg;
    assign response   = response_reg;
    assign wr_full    = ADDR_FULL_W'(request.vertex_index);

    assign last_col  = ({1'b0, x_reg} + 12'd2) >= {1'b0, cols_reg};
    assign last_cell = last_col && (({1'b0, z_reg} + 12'd2) >= {1'b0, rows_reg});
    assign right_hit = &edge_ok_reg[2:0];
    assign left_hit  = &edge_ok_reg[5:3];

    assign v0 = right_sel_reg ? corner_reg[CORNER_UL] : corner_reg[CORNER_LL];
    assign v1 = right_sel_reg ? corner_reg[CORNER_UR] : corner_reg[CORNER_UL];
    assign v2 = corner_reg[CORNER_LR];
    assign e0x = sub33(v0.x, v1.x);
    assign e0y = sub33(v0.y, v1.y);
    assign e0z = sub33(v0.z, v1.z);
    assign e1x = sub33(v0.x, v2.x);
    assign e1y = sub33(v0.y, v2.y);
    assign e1z = sub33(v0.z, v2.z);
    assign dx  = sub33(px_reg, v0.x);
    assign dz  = sub33(pz_reg, v0.z);

    assign edge_sel = (step_reg < STEP_W'(6)) ? step_reg : 3'd0;
    assign head_v   = corner_reg[EDGE_HEAD[edge_sel]];
    assign tail_v   = corner_reg[EDGE_TAIL[edge_sel]];

    assign prod_diff = {prod_a_reg[PROD_W-1], prod_a_reg} - {prod_b_reg[PROD_W-1], prod_b_reg};
    assign prod_sum  = {{(NUM_W-PROD_W){prod_a_reg[PROD_W-1]}}, prod_a_reg}
                     + {{(NUM_W-PROD_W){prod_b_reg[PROD_W-1]}}, prod_b_reg};
    assign num_full  = num_reg + (prod_sum <<< 32);
    assign num_abs   = num_full[NUM_W-1] ? NUM_W'(-num_full) : NUM_W'(num_full);
    assign ny_abs    = ny_reg[NORM_W-1] ? REM_W'(-{ny_reg[NORM_W-1], ny_reg})
                                        : REM_W'({1'b0, ny_reg});
    assign rem_shift = {rem_reg[REM_W-2:0], dvd_reg[NUM_W-1]};

    assign ny_zero  = ny_reg == '0;
    assign num_zero = num_reg == '0;
    assign div_last = ny_zero || (div_cnt_reg == DIV_CNT_W'(NUM_W-1));
    assign quo_over = quo_reg > NUM_W'(QUOT_LIMIT);
    assign quot_neg = num_reg[NUM_W-1] ^ ny_reg[NORM_W-1];

    always_comb
    begin
        if (num_zero)
            mag = '0;
        else if (ny_zero || quo_over)
            mag = QUOT_LIMIT;
        else
            mag = quo_reg[62:0];
        quot_s = quot_neg ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
        h64    = 64'(v0.y) - quot_s;
        if (h64 > 64'sd2147483647)
            h_sat = 32'sh7fff_ffff;
        else if (h64 < -64'sd2147483648)
            h_sat = 32'sh8000_0000;
        else
            h_sat = h64[COORD_W-1:0];
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        case (state_reg)
            ST_IDLE:
            begin
                step_next = '0;
                if (accept && is_query && enable_reg && !small_grid)
                    state_next = ST_READ;
            end
            ST_READ:
            begin
                step_next = step_reg + 3'd1;
                if (step_reg == STEP_W'(4))
                begin
                    state_next = ST_EDGE;
                    step_next  = '0;
                end
            end
            ST_EDGE:
            begin
                step_next = step_reg + 3'd1;
                if (step_reg == STEP_W'(6))
                begin
                    state_next = ST_DECIDE;
                    step_next  = '0;
                end
            end
            ST_DECIDE:
            begin
                step_next = '0;
                if (right_hit || left_hit)
                    state_next = ST_NORMAL;
                else if (last_cell)
                    state_next = ST_FINISH;
                else
                    state_next = ST_READ;
            end
            ST_NORMAL:
            begin
                step_next = step_reg + 3'd1;
                if (step_reg == STEP_W'(3))
                begin
                    state_next = ST_NUMER;
                    step_next  = '0;
                end
            end
            ST_NUMER:
            begin
                step_next = step_reg + 3'd1;
                if (step_reg == STEP_W'(2))
                begin
                    state_next = ST_DIVIDE;
                    step_next  = '0;
                end
            end
            ST_DIVIDE:
            begin
                if (div_last)
                    state_next = ST_FINISH;
            end
            ST_FINISH:
                state_next = ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    // memory and multiplier control
    always_comb
    begin
        mem_we  = 1'b0;
        rd_en   = 1'b0;
        rd_addr = '0;
        mul_a0  = '0;
        mul_b0  = '0;
        mul_a1  = '0;
        mul_b1  = '0;
        case (state_reg)
            ST_IDLE:
                mem_we = accept && !is_query && (wr_full < ADDR_FULL_W'(MAX_VERTICES));
            ST_READ:
            begin
                rd_en = step_reg < STEP_W'(4);
                case (step_reg[1:0])
                    CORNER_UL: rd_addr = base_reg + ADDR_FULL_W'(x_reg);
                    CORNER_UR: rd_addr = base_reg + ADDR_FULL_W'(x_reg) + 23'd1;
                    CORNER_LL: rd_addr = base_reg + ADDR_FULL_W'(cols_reg)
                                       + ADDR_FULL_W'(x_reg);
                    default:   rd_addr = base_reg + ADDR_FULL_W'(cols_reg)
                                       + ADDR_FULL_W'(x_reg) + 23'd1;
                endcase
            end
            ST_EDGE:
            begin
                mul_a0 = ext35(sub33(head_v.z, tail_v.z));
                mul_b0 = sub33(px_reg, tail_v.x);
                mul_a1 = ext35(sub33(head_v.x, tail_v.x));
                mul_b1 = sub33(pz_reg, tail_v.z);
            end
            ST_NORMAL:
            begin
                case (step_reg)
                    3'd0:
                    begin
                        mul_a0 = ext35(e0y); mul_b0 = e1z;
                        mul_a1 = ext35(e0z); mul_b1 = e1y;
                    end
                    3'd1:
                    begin
                        mul_a0 = ext35(e0z); mul_b0 = e1x;
                        mul_a1 = ext35(e0x); mul_b1 = e1z;
                    end
                    default:
                    begin
                        mul_a0 = ext35(e0x); mul_b0 = e1y;
                        mul_a1 = ext35(e0y); mul_b1 = e1x;
                    end
                endcase
            end
            ST_NUMER:
            begin
                mul_b0 = dx;
                mul_b1 = dz;
                if (step_reg == '0)
                begin
                    mul_a0 = {3'b000, nx_reg[31:0]};
                    mul_a1 = {3'b000, nz_reg[31:0]};
                end
                else
                begin
                    mul_a0 = nx_reg[NORM_W-1:32];
                    mul_a1 = nz_reg[NORM_W-1:32];
                end
            end
            default:
            begin
                mem_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[wr_full[ADDR_W-1:0]] <= '{x: request.coord_x, y: request.coord_y,
                                         z: request.coord_z};
        if (rd_en)
        begin
            rd_q_reg    <= mem[rd_addr[ADDR_W-1:0]];
            rd_zero_reg <= rd_addr >= ADDR_FULL_W'(MAX_VERTICES);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            step_reg   <= '0;
            cols_reg   <= CFG_W'(2);
            rows_reg   <= CFG_W'(2);
            enable_reg <= 1'b1;
            done_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
            done_reg  <= (accept && is_query && (!enable_reg || small_grid))
                         || (state_reg == ST_FINISH);
            if (cfg_we)
            begin
                case (cfg_idx)
                    REG_GRID_COLUMNS:  cols_reg   <= cfg_data;
                    REG_GRID_ROWS:     rows_reg   <= cfg_data;
                    REG_QUERY_ENABLED: enable_reg <= cfg_data[0];
                    default:           enable_reg <= enable_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        prod_a_reg <= mul_a0 * mul_b0;
        prod_b_reg <= mul_a1 * mul_b1;
        case (state_reg)
            ST_IDLE:
            begin
                x_reg     <= '0;
                z_reg     <= '0;
                base_reg  <= '0;
                found_reg <= 1'b0;
                px_reg    <= request.coord_x;
                py_reg    <= request.coord_y;
                pz_reg    <= request.coord_z;
                if (!enable_reg)
                    response_reg <= '{height: '0, triangle_found: 1'b0,
                                      flat_normal_error: 1'b0};
                else
                    response_reg <= '{height: request.coord_y, triangle_found: 1'b0,
                                      flat_normal_error: 1'b0};
            end
            ST_READ:
            begin
                if (step_reg != '0)
                    corner_reg[2'(step_reg - 3'd1)] <= rd_zero_reg ? '0 : rd_q_reg;
            end
            ST_EDGE:
            begin
                if (step_reg != '0)
                    edge_ok_reg[step_reg - 3'd1] <= prod_diff[PROD_W] || (prod_diff == '0);
            end
            ST_DECIDE:
            begin
                right_sel_reg <= right_hit;
                found_reg     <= right_hit || left_hit;
                if (!right_hit && !left_hit && !last_cell)
                begin
                    if (last_col)
                    begin
                        x_reg    <= '0;
                        z_reg    <= z_reg + CFG_W'(1);
                        base_reg <= base_reg + ADDR_FULL_W'(cols_reg);
                    end
                    else
                        x_reg <= x_reg + CFG_W'(1);
                end
            end
            ST_NORMAL:
            begin
                case (step_reg)
                    3'd1:    nx_reg <= prod_diff[NORM_W-1:0];
                    3'd2:    ny_reg <= prod_diff[NORM_W-1:0];
                    3'd3:    nz_reg <= prod_diff[NORM_W-1:0];
                    default: nx_reg <= nx_reg;
                endcase
            end
            ST_NUMER:
            begin
                if (step_reg == 3'd1)
                    num_reg <= prod_sum;
                else if (step_reg == 3'd2)
                begin
                    num_reg     <= num_full;
                    dvd_reg     <= num_abs;
                    rem_reg     <= '0;
                    quo_reg     <= '0;
                    div_cnt_reg <= '0;
                end
            end
            ST_DIVIDE:
            begin
                dvd_reg     <= {dvd_reg[NUM_W-2:0], 1'b0};
                div_cnt_reg <= div_cnt_reg + DIV_CNT_W'(1);
                if (rem_shift >= ny_abs)
                begin
                    rem_reg <= rem_shift - ny_abs;
                    quo_reg <= {quo_reg[NUM_W-2:0], 1'b1};
                end
                else
                begin
                    rem_reg <= rem_shift;
                    quo_reg <= {quo_reg[NUM_W-2:0], 1'b0};
                end
            end
            ST_FINISH:
            begin
                if (found_reg)
                    response_reg <= '{height: h_sat, triangle_found: 1'b1,
                                      flat_normal_error: ny_zero};
                else
                    response_reg <= '{height: py_reg, triangle_found: 1'b0,
                                      flat_normal_error: 1'b0};
            end
            default:
            begin
                found_reg <= found_reg;
            end
        endcase
    end

    a_done_source: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(state_reg == ST_FINISH)
                 || $past(start && !busy && request.opcode == OP_QUERY))
        else $error("result strobe without a finished query");

    a_flat_needs_hit: assert property (@(posedge clk) disable iff (!rst_n)
        done && response.flat_normal_error |-> response.triangle_found)
        else $error("flat normal flagged without a triangle");

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result presented while busy");

endmodule

// ----- test/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Checks the grid terrain height query block against its own software model.
// Meshes of varied shape and orientation are loaded with write items and then
// queried at positions inside and outside the mesh, with random idle bursts on
// the request side. Every query result is compared field by field with the
// prediction made when the item was taken.
// ----------------------------------------------------------------------------
module tb_top;
    import gthq_pkg::*;

    typedef logic signed [127:0] wide_t;

    localparam int LIMIT_CYCLES = 2000000;
    localparam int ITEM_TARGET  = 140;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_idx;
    logic [CFG_W-1:0]     cfg_data;
    logic                 start;
    logic                 busy;
    request_t             request;
    logic                 done;
    response_t            response;

    request_t  pending_items[$];
    response_t heights_due[$];
    vertex_t   mesh_store[DEF_MAX_VERTICES];
    int        grid_cols;
    int        grid_rows_q;
    bit        query_on;
    int        gap_left;
    bit        quiet;
    int        err_count;
    int        cycles;
    int        items_sent;
    int        mesh_cols;
    int        mesh_rows;
    int        mesh_x0;
    int        mesh_z0;
    int        step_x;
    int        step_z;

    grid_terrain_height_query i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_idx  (cfg_idx),
        .cfg_data (cfg_data),
        .start    (start),
        .busy     (busy),
        .request  (request),
        .done     (done),
        .response (response)
    );

    always
    begin
        clk = 1'b1;
        #2;
        clk = 1'b0;
        #2;
    end

    function automatic wide_t wx(input logic signed [31:0] v);
        wx = wide_t'(v);
    endfunction

    function automatic bit edge_inside(input vertex_t a, input vertex_t b,
                                       input logic signed [31:0] px,
                                       input logic signed [31:0] pz);
        wide_t c;
        c = (wx(a.z) - wx(b.z)) * (wx(px) - wx(b.x))
          - (wx(a.x) - wx(b.x)) * (wx(pz) - wx(b.z));
        edge_inside = (c <= 0);
    endfunction

    function automatic logic signed [31:0] plane_y(input request_t p, input vertex_t v0,
                                                   input vertex_t v1, input vertex_t v2,
                                                   output bit flat);
        wide_t e0x, e0y, e0z, e1x, e1y, e1z, nx, ny, nz, num, mag, lim, q, h;
        bit    neg;
        e0x  = wx(v0.x) - wx(v1.x);
        e0y  = wx(v0.y) - wx(v1.y);
        e0z  = wx(v0.z) - wx(v1.z);
        e1x  = wx(v0.x) - wx(v2.x);
        e1y  = wx(v0.y) - wx(v2.y);
        e1z  = wx(v0.z) - wx(v2.z);
        nx   = e0y * e1z - e0z * e1y;
        ny   = e0z * e1x - e0x * e1z;
        nz   = e0x * e1y - e0y * e1x;
        num  = nx * (wx(p.coord_x) - wx(v0.x)) + nz * (wx(p.coord_z) - wx(v0.z));
        lim  = wide_t'(1) <<< 62;
        neg  = (num < 0) != (ny < 0);
        flat = (ny == 0);
        if (num == 0)
        begin
            mag = 0;
        end
        else if (flat)
        begin
            mag = lim;
        end
        else
        begin
            mag = (num < 0 ? -num : num) / (ny < 0 ? -ny : ny);
            if (mag > lim)
                mag = lim;
        end
        q = neg ? -mag : mag;
        h = wx(v0.y) - q;
        if (h > wide_t'(32'sh7fffffff))
            h = wide_t'(32'sh7fffffff);
        if (h < wx(32'sh80000000))
            h = wx(32'sh80000000);
        plane_y = h[31:0];
    endfunction

    function automatic response_t predict_height(input request_t p);
        response_t r;
        vertex_t   ll, ul, lr, ur;
        bit        flat;
        r.height            = p.coord_y;
        r.triangle_found    = 1'b0;
        r.flat_normal_error = 1'b0;
        if (!query_on)
        begin
            r.height = '0;
        end
        else if (grid_cols >= 2 && grid_rows_q >= 2)
        begin
            for (int z = 0; z + 1 < grid_rows_q && !r.triangle_found; z++)
            begin
                for (int x = 0; x + 1 < grid_cols && !r.triangle_found; x++)
                begin
                    ll = mesh_store[x + grid_cols * (z + 1)];
                    ul = mesh_store[x + grid_cols * z];
                    lr = mesh_store[x + grid_cols * (z + 1) + 1];
                    ur = mesh_store[x + grid_cols * z + 1];
                    if (edge_inside(lr, ul, p.coord_x, p.coord_z)
                        && edge_inside(ur, lr, p.coord_x, p.coord_z)
                        && edge_inside(ul, ur, p.coord_x, p.coord_z))
                    begin
                        r.height            = plane_y(p, ul, ur, lr, flat);
                        r.triangle_found    = 1'b1;
                        r.flat_normal_error = flat;
                    end
                    else if (edge_inside(ll, ul, p.coord_x, p.coord_z)
                             && edge_inside(ul, lr, p.coord_x, p.coord_z)
                             && edge_inside(lr, ll, p.coord_x, p.coord_z))
                    begin
                        r.height            = plane_y(p, ll, ul, lr, flat);
                        r.triangle_found    = 1'b1;
                        r.flat_normal_error = flat;
                    end
                end
            end
        end
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start    <= 1'b0;
            request  <= '0;
            gap_left <= 0;
        end
        else if (start && busy)
        begin
        end
        else if (gap_left > 0)
        begin
            start    <= 1'b0;
            gap_left <= gap_left - 1;
        end
        else if (pending_items.size() > 0)
        begin
            if (!quiet && $urandom_range(0, 5) == 0)
            begin
                start    <= 1'b0;
                gap_left <= $urandom_range(0, 12);
            end
            else
            begin
                start   <= 1'b1;
                request <= pending_items.pop_front();
            end
        end
        else
        begin
            start <= 1'b0;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && start && !busy)
        begin
            if (request.opcode == OP_WRITE)
            begin
                mesh_store[request.vertex_index].x = request.coord_x;
                mesh_store[request.vertex_index].y = request.coord_y;
                mesh_store[request.vertex_index].z = request.coord_z;
            end
            else
            begin
                heights_due.push_back(predict_height(request));
            end
        end
        if (rst_n && done)
        begin
            if (heights_due.size() == 0)
            begin
                $error("unexpected result: height %0d", response.height);
                err_count++;
            end
            else
            begin
                response_t want;
                want = heights_due.pop_front();
                if (response.height !== want.height)
                begin
                    $error("height: expected %0d, actual %0d", want.height, response.height);
                    err_count++;
                end
                if (response.triangle_found !== want.triangle_found)
                begin
                    $error("triangle_found: expected %0b, actual %0b",
                           want.triangle_found, response.triangle_found);
                    err_count++;
                end
                if (response.flat_normal_error !== want.flat_normal_error)
                begin
                    $error("flat_normal_error: expected %0b, actual %0b",
                           want.flat_normal_error, response.flat_normal_error);
                    err_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > LIMIT_CYCLES)
        begin
            $display("tb_top: errors");
            $finish;
        end
    end

    task automatic program_grid(input int c, input int r, input bit en);
        @(posedge clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= REG_GRID_COLUMNS;
        cfg_data <= CFG_W'(c);
        grid_cols = c;
        @(posedge clk);
        cfg_idx  <= REG_GRID_ROWS;
        cfg_data <= CFG_W'(r);
        grid_rows_q = r;
        @(posedge clk);
        cfg_idx  <= REG_QUERY_ENABLED;
        cfg_data <= CFG_W'(en);
        query_on = en;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic push_item(input logic op, input int idx, input int x, input int y,
                             input int z);
        request_t it;
        it.opcode       = op;
        it.vertex_index = VIDX_W'(idx);
        it.coord_x      = x;
        it.coord_y      = y;
        it.coord_z      = z;
        pending_items.push_back(it);
        items_sent++;
    endtask

    task automatic drain;
        @(negedge clk);
        while (pending_items.size() > 0 || start || heights_due.size() > 0)
            @(negedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic load_mesh(input int c, input int r, input bit noisy);
        int x, y, z;
        mesh_cols = c;
        mesh_rows = r;
        mesh_x0   = int'($urandom_range(0, 1 << 27)) - (1 << 26);
        mesh_z0   = int'($urandom_range(0, 1 << 27)) - (1 << 26);
        step_x    = int'($urandom_range(1 << 14, 1 << 20)) * ($urandom_range(0, 1) ? 1 : -1);
        step_z    = int'($urandom_range(1 << 14, 1 << 20)) * ($urandom_range(0, 1) ? 1 : -1);
        for (int j = 0; j < r; j++)
        begin
            for (int i = 0; i < c; i++)
            begin
                x = mesh_x0 + i * step_x + int'($urandom_range(0, 4095)) - 2048;
                z = mesh_z0 + j * step_z + int'($urandom_range(0, 4095)) - 2048;
                y = int'($urandom_range(0, 1 << 25)) - (1 << 24);
                if (noisy)
                begin
                    x = $urandom;
                    y = $urandom;
                    z = $urandom;
                end
                push_item(OP_WRITE, i + c * j, x, y, z);
            end
        end
        if (c * r < DEF_MAX_VERTICES)
            push_item(OP_WRITE, $urandom_range(c * r, DEF_MAX_VERTICES - 1),
                      $urandom, $urandom, $urandom);
    endtask

    task automatic query_mesh(input int n);
        int x, z;
        for (int k = 0; k < n; k++)
        begin
            x = mesh_x0 + int'($urandom_range(0, 1 << 20)) * (mesh_cols - 1)
                * (step_x < 0 ? -1 : 1);
            z = mesh_z0 + int'($urandom_range(0, 1 << 20)) * (mesh_rows - 1)
                * (step_z < 0 ? -1 : 1);
            if ($urandom_range(0, 4) == 0)
            begin
                x = $urandom;
                z = $urandom;
            end
            push_item(OP_QUERY, $urandom, x, $urandom, z);
        end
    endtask

    initial
    begin
        rst_n        = 1'b0;
        cfg_we       = 1'b0;
        cfg_idx      = '0;
        cfg_data     = '0;
        quiet        = 1'b0;
        err_count    = 0;
        cycles       = 0;
        items_sent   = 0;
        grid_cols    = 2;
        grid_rows_q  = 2;
        query_on     = 1'b1;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // degenerate cell: every corner at the origin in x-z
        program_grid(2, 2, 1'b1);
        for (int i = 0; i < 4; i++)
            push_item(OP_WRITE, i, 0, 100 * i + 7, 0);
        push_item(OP_QUERY, 0, 0, 5, 0);
        push_item(OP_QUERY, 1023, 32'sh80000000, 32'sh7fffffff, 32'sh7fffffff);
        push_item(OP_QUERY, 0, 32'sh7fffffff, 32'sh80000000, 32'sh80000000);
        drain();
        load_mesh(2, 2, 1'b0);
        query_mesh(4);
        drain();
        load_mesh(3, 3, 1'b1);
        query_mesh(3);
        drain();
        program_grid(3, 3, 1'b0);
        push_item(OP_QUERY, 0, 1, 2, 3);
        drain();
        program_grid(1023, 1, 1'b1);
        push_item(OP_QUERY, 0, 4, -9, 6);
        drain();
        program_grid(1024, 1024, 1'b0);
        push_item(OP_QUERY, 0, -4, 9, -6);
        drain();
        program_grid(0, 0, 1'b1);
        push_item(OP_QUERY, 0, 7, 33, 1);
        drain();
        program_grid(2, 12, 1'b1);
        load_mesh(2, 12, 1'b0);
        query_mesh(2);
        drain();

        while (items_sent < ITEM_TARGET)
        begin
            int c, r;
            c = $urandom_range(2, 5);
            r = $urandom_range(2, 5);
            if (items_sent > ITEM_TARGET - 40)
                quiet = 1'b1;
            program_grid(c, r, $urandom_range(0, 5) != 0);
            load_mesh(c, r, $urandom_range(0, 4) == 0);
            query_mesh($urandom_range(4, 12));
            drain();
        end

        repeat (50) @(posedge clk);
        if (err_count == 0)
            $display("tb_top: clean");
        else
            $display("tb_top: errors");
        $finish;
    end

endmodule
